FILE: src/ft12_pkg.sv
// Shared types, constants and helpers for the FT1.2 frame receiver.
package ft12_pkg;

  localparam logic [7:0] START_FIX = 8'h10;
  localparam logic [7:0] START_VAR = 8'h68;
  localparam logic [7:0] END_BYTE  = 8'h16;

  localparam logic CFG_ADDRESS_BYTES = 1'b0;
  localparam logic CFG_TIMEOUT_TICKS = 1'b1;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic        ok;
    logic        fail;
    logic        tout;
    logic [7:0]  control;
    logic [15:0] address;
    logic [7:0]  length;
  } rx_status_t;

  // tuser of the result word, lowest bit first in declaration order reversed
  typedef struct packed {
    logic timed_out;
    logic variable_fail;
    logic fixed_fail;
    logic variable_ok;
    logic fixed_ok;
  } out_flags_t;

  typedef struct packed {
    logic [7:0]  user_length;
    logic [15:0] link_address;
    logic [7:0]  control_field;
  } out_data_t;

  // 0 acts as 1, 3 acts as 2
  function automatic logic [1:0] addr_count(input logic [1:0] ab);
    logic [1:0] r;
    r = ab;
    if (ab == 2'd0) r = 2'd1;
    if (ab == 2'd3) r = 2'd2;
    return r;
  endfunction

endpackage

FILE: src/ft12_frame_receiver_core.sv
// Top level of the FT1.2 frame receiver: config registers, receivers, result register.
// Each input word is a line byte or a timer tick; it is fed to a fixed-frame and a
// variable-frame receiver at once, and exactly one result word follows in the cycle
// after acceptance. The input is ready whenever the result register is empty or its
// word leaves in the same cycle, so throughput is one word per cycle unless the output
// side stalls; a waiting result holds the input off. Configuration writes are always
// ready and are meant to happen while the block is idle.
module ft12_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // control_field, link_address, user_length
  output logic [4:0]  m_axis_tuser,   // fixed_ok, variable_ok, fixed_fail, variable_fail, timed_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [1:0] address_bytes;
  logic [7:0] timeout_ticks;
  logic [1:0] acount;
  logic       accept;
  logic       tick;

  ft12_pkg::rx_status_t fix_st;
  ft12_pkg::rx_status_t var_st;
  ft12_pkg::out_flags_t flags, flags_next;
  ft12_pkg::out_data_t  data, data_next;

  assign cfg_ready     = 1'b1;
  assign acount        = ft12_pkg::addr_count(address_bytes);
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign tick          = (s_axis_tuser == ft12_pkg::MODE_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      address_bytes <= 2'd2;
      timeout_ticks <= 8'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ft12_pkg::CFG_ADDRESS_BYTES: address_bytes <= cfg_data[1:0];
        ft12_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  ft12_fix_rx u_fix (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .tick    (tick),
    .rx_byte (s_axis_tdata),
    .acount  (acount),
    .timeout (timeout_ticks),
    .status  (fix_st)
  );

  ft12_var_rx u_var (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .tick    (tick),
    .rx_byte (s_axis_tdata),
    .acount  (acount),
    .timeout (timeout_ticks),
    .status  (var_st)
  );

  always_comb begin
    flags_next.fixed_ok      = fix_st.ok;
    flags_next.variable_ok   = var_st.ok;
    flags_next.fixed_fail    = fix_st.fail;
    flags_next.variable_fail = var_st.fail;
    flags_next.timed_out     = fix_st.tout || var_st.tout;
    data_next                = '0;
    priority if (var_st.ok) begin
      data_next.control_field = var_st.control;
      data_next.link_address  = var_st.address;
      data_next.user_length   = var_st.length;
    end else if (fix_st.ok) begin
      data_next.control_field = fix_st.control;
      data_next.link_address  = fix_st.address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flags <= flags_next;
      data  <= data_next;
    end
  end

  assign m_axis_tuser = flags;
  assign m_axis_tdata = data;

`ifndef SYNTH
  a_tick_no_frame_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && flags.timed_out |->
      !flags.fixed_ok && !flags.variable_ok && !flags.fixed_fail && !flags.variable_fail)
    else $error("timeout reported together with frame flags");

  a_ok_fail_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      !(flags.fixed_ok && flags.fixed_fail) && !(flags.variable_ok && flags.variable_fail))
    else $error("receiver reported ok and fail on one byte");

  a_fields_zero_without_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !flags.fixed_ok && !flags.variable_ok |-> data == '0)
    else $error("value fields set without a completed frame");

  a_fixed_no_length: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && flags.fixed_ok && !flags.variable_ok |-> data.user_length == 8'd0)
    else $error("length reported for fixed frame");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid)
    else $error("accepted word produced no result");
`endif

endmodule

FILE: src/ft12_fix_rx.sv
// Fixed-length frame receiver: 0x10, C, A, CS, 0x16.
module ft12_fix_rx (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  tick,
  input  logic [7:0]            rx_byte,
  input  logic [1:0]            acount,
  input  logic [7:0]            timeout,
  output ft12_pkg::rx_status_t  status
);

  logic        active, active_next;
  logic [2:0]  position, position_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  control, control_next;
  logic [15:0] address, address_next;
  logic [7:0]  age, age_next;

  logic        starting;
  logic [2:0]  wpos;
  logic [7:0]  wsum;
  logic [7:0]  wctl;
  logic [15:0] waddr;
  logic [2:0]  a3;
  logic        good;

  assign a3       = {1'b0, acount};
  assign starting = !active && (rx_byte == ft12_pkg::START_FIX);
  assign wpos     = starting ? 3'd0 : position;
  assign wsum     = starting ? 8'd0 : sum;
  assign wctl     = starting ? 8'd0 : control;
  assign waddr    = starting ? 16'd0 : address;
  assign good     = (wpos == a3 + 3'd3) && (rx_byte == ft12_pkg::END_BYTE) && (wsum == 8'd0);

  always_comb begin
    active_next   = active;
    position_next = position;
    sum_next      = sum;
    control_next  = control;
    address_next  = address;
    age_next      = age;
    status        = '0;
    if (tick) begin
      if (active) begin
        age_next = age + 8'd1;
        if (age_next >= timeout) begin
          active_next   = 1'b0;
          position_next = 3'd0;
          status.tout   = 1'b1;
        end
      end
    end else if (active || starting) begin
      active_next  = 1'b1;
      sum_next     = wsum;
      control_next = wctl;
      address_next = waddr;
      if (starting) age_next = 8'd0;
      if (wpos == 3'd0) begin
        position_next = 3'd1;
      end else if (wpos == 3'd1) begin
        control_next  = rx_byte;
        sum_next      = wsum + rx_byte;
        position_next = 3'd2;
      end else if (wpos <= a3 + 3'd1) begin
        address_next  = waddr | (wpos[0] ? {rx_byte, 8'h00} : {8'h00, rx_byte});
        sum_next      = wsum + rx_byte;
        position_next = wpos + 3'd1;
      end else if (wpos == a3 + 3'd2) begin
        sum_next      = wsum - rx_byte;
        position_next = wpos + 3'd1;
      end else begin
        active_next    = 1'b0;
        position_next  = 3'd0;
        status.ok      = good;
        status.fail    = !good;
        status.control = wctl;
        status.address = waddr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      position <= 3'd0;
      sum      <= 8'd0;
      control  <= 8'd0;
      address  <= 16'd0;
      age      <= 8'd0;
    end else if (step) begin
      active   <= active_next;
      position <= position_next;
      sum      <= sum_next;
      control  <= control_next;
      address  <= address_next;
      age      <= age_next;
    end
  end

endmodule

FILE: src/ft12_var_rx.sv
// Variable-length frame receiver: 0x68, L, L, 0x68, user bytes, CS, 0x16.
module ft12_var_rx (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  tick,
  input  logic [7:0]            rx_byte,
  input  logic [1:0]            acount,
  input  logic [7:0]            timeout,
  output ft12_pkg::rx_status_t  status
);

  logic        active, active_next;
  logic [8:0]  position, position_next;
  logic [7:0]  length, length_next;
  logic        hdr_bad, hdr_bad_next;
  logic [7:0]  sum, sum_next;
  logic [7:0]  control, control_next;
  logic [15:0] address, address_next;
  logic [7:0]  age, age_next;

  logic        starting;
  logic [8:0]  wpos;
  logic [7:0]  wlen;
  logic        whb;
  logic [7:0]  wsum;
  logic [7:0]  wctl;
  logic [15:0] waddr;
  logic [8:0]  data_end;
  logic [8:0]  upos;
  logic        good;

  assign starting = !active && (rx_byte == ft12_pkg::START_VAR);
  assign wpos     = starting ? 9'd0 : position;
  assign wlen     = starting ? 8'd0 : length;
  assign whb      = starting ? 1'b0 : hdr_bad;
  assign wsum     = starting ? 8'd0 : sum;
  assign wctl     = starting ? 8'd0 : control;
  assign waddr    = starting ? 16'd0 : address;
  assign data_end = {1'b0, wlen} + 9'd4;
  assign upos     = wpos - 9'd4;
  assign good     = !whb && (rx_byte == ft12_pkg::END_BYTE) && (wsum == 8'd0);

  always_comb begin
    active_next   = active;
    position_next = position;
    length_next   = length;
    hdr_bad_next  = hdr_bad;
    sum_next      = sum;
    control_next  = control;
    address_next  = address;
    age_next      = age;
    status        = '0;
    if (tick) begin
      if (active) begin
        age_next = age + 8'd1;
        if (age_next >= timeout) begin
          active_next   = 1'b0;
          position_next = 9'd0;
          status.tout   = 1'b1;
        end
      end
    end else if (active || starting) begin
      active_next  = 1'b1;
      length_next  = wlen;
      hdr_bad_next = whb;
      sum_next     = wsum;
      control_next = wctl;
      address_next = waddr;
      if (starting) age_next = 8'd0;
      if (wpos == 9'd0) begin
        position_next = 9'd1;
      end else if (wpos == 9'd1) begin
        length_next = rx_byte;
        if (rx_byte < {6'd0, acount} + 8'd1) hdr_bad_next = 1'b1;
        position_next = 9'd2;
      end else if (wpos == 9'd2) begin
        if (rx_byte != wlen) hdr_bad_next = 1'b1;
        position_next = 9'd3;
      end else if (wpos == 9'd3) begin
        if (rx_byte != ft12_pkg::START_VAR) hdr_bad_next = 1'b1;
        position_next = 9'd4;
      end else if (wpos < data_end) begin
        if (upos == 9'd0) begin
          control_next = rx_byte;
        end else if (upos <= {7'd0, acount}) begin
          address_next = waddr | (upos[0] ? {8'h00, rx_byte} : {rx_byte, 8'h00});
        end
        sum_next      = wsum + rx_byte;
        position_next = wpos + 9'd1;
      end else if (wpos == data_end) begin
        sum_next      = wsum - rx_byte;
        position_next = wpos + 9'd1;
      end else begin
        active_next    = 1'b0;
        position_next  = 9'd0;
        status.ok      = good;
        status.fail    = !good;
        status.control = wctl;
        status.address = waddr;
        status.length  = wlen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      position <= 9'd0;
      length   <= 8'd0;
      hdr_bad  <= 1'b0;
      sum      <= 8'd0;
      control  <= 8'd0;
      address  <= 16'd0;
      age      <= 8'd0;
    end else if (step) begin
      active   <= active_next;
      position <= position_next;
      length   <= length_next;
      hdr_bad  <= hdr_bad_next;
      sum      <= sum_next;
      control  <= control_next;
      address  <= address_next;
      age      <= age_next;
    end
  end

endmodule
